### rtl/arpt_pkg.sv
// Shared types, constants and rounding helpers for the axis rotation block.
package arpt_pkg;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [64:0] DOT_LIM = 65'sd8589934591;

	// Configuration register indexes.
	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_AXIS_X = 3'd3;
	localparam logic [2:0] REG_AXIS_Y = 3'd4;
	localparam logic [2:0] REG_AXIS_Z = 3'd5;
	localparam logic [2:0] REG_MIN_RADIUS = 3'd6;

	// Square root and divide pipelines: bits resolved per stage.
	localparam int SQ_ITERS = 31;
	localparam int DV_ITERS = 31;
	localparam int BITS_PER_STAGE = 4;
	localparam int SQ_ST = (SQ_ITERS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int DV_ST = (DV_ITERS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

	// Ten front stages, square root, divide, sign stage.
	localparam int LANE_LAT = 10 + SQ_ST + DV_ST + 1;
	localparam int COMB_LAT = 6;

	typedef struct packed {
		logic            deg;
		logic [2:0][31:0] u;
	} unit_t;

	function automatic logic signed [65:0] rnd30(input logic signed [65:0] x);
		return (x + 66'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [31:0] sat30(input logic signed [65:0] x);
		if (x > 66'sd1073741824)
			return ONE_Q30;
		else if (x < -66'sd1073741824)
			return -ONE_Q30;
		else
			return 32'(x);
	endfunction

endpackage

### rtl/arpt_ortho.sv
// Projection of one point onto the plane normal to the axis, normalized to a unit vector.
module arpt_ortho #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] p [3],
	input  logic signed [31:0]            center [3],
	input  logic signed [31:0]            k [3],
	input  logic [30:0]                   min_radius,
	output arpt_pkg::unit_t               u
);
	import arpt_pkg::*;

	localparam int PRE_SHIFT = (COORD_WIDTH > 32) ? COORD_WIDTH - 32 : 0;

	logic signed [32:0] v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3];
	logic signed [62:0] pr_s2 [3];
	logic signed [34:0] d_s3;
	logic signed [66:0] e_s4 [3];
	logic [33:0]        mag_s5 [3], mag_s6 [3], mag_s7 [3];
	logic [2:0]         sgn_s5, sgn_s6, sgn_s7, sgn_s8, sgn_s9, sgn_s10, sgn_s27;
	logic [33:0]        m_s6;
	logic [61:0]        sq_s6 [3];
	logic [61:0]        mr2_s6;
	logic               deg_s7, deg_s8, deg_s9, deg_s10, deg_s27;
	logic [5:0]         msb_s7;
	logic [29:0]        nm_s8 [3], nm_s9 [3], nm_s10 [3];
	logic [59:0]        nsq_s9 [3];
	logic [61:0]        r2n_s10;
	logic signed [31:0] u_s27 [3];

	logic signed [64:0] prod [3];
	logic signed [64:0] acc, rd;
	logic signed [66:0] e_c [3];
	logic signed [66:0] o_c [3];
	logic [33:0]        m_c;
	logic [30:0]        mr_c;
	logic [63:0]        r2_c;
	logic [5:0]         msb_c;
	logic [63:0]        sh_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = k[i] * v_s1[i];
			e_c[i] = d_s3 * k[i];
			o_c[i] = 67'(v_s4[i]) - 67'(rnd30(66'(e_s4[i])));
		end
		acc = 65'(pr_s2[0]) + 65'(pr_s2[1]) + 65'(pr_s2[2]);
		rd = (acc + 65'sd134217728) >>> 28;
		m_c = mag_s5[0];
		if (mag_s5[1] > m_c) m_c = mag_s5[1];
		if (mag_s5[2] > m_c) m_c = mag_s5[2];
		mr_c = min_radius >> PRE_SHIFT;
		r2_c = 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
		msb_c = '0;
		for (int b = 0; b < 34; b++)
			if (m_s6[b]) msb_c = 6'(b);
		for (int i = 0; i < 3; i++) begin
			if (msb_s7 >= 6'd29)
				sh_c[i] = 64'(mag_s7[i]) >> (msb_s7 - 6'd29);
			else
				sh_c[i] = 64'(mag_s7[i]) << (6'd29 - msb_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= 33'(p[i] >>> PRE_SHIFT) - 33'(center[i] >>> PRE_SHIFT);
				pr_s2[i] <= 63'(prod[i] >>> 2);
				v_s2[i] <= v_s1[i];
				v_s3[i] <= v_s2[i];
				e_s4[i] <= e_c[i];
				v_s4[i] <= v_s3[i];
				mag_s5[i] <= o_c[i][66] ? 34'(-o_c[i]) : 34'(o_c[i]);
				sgn_s5[i] <= o_c[i][66];
				mag_s6[i] <= mag_s5[i];
				sq_s6[i] <= 62'(mag_s5[i][30:0]) * 62'(mag_s5[i][30:0]);
				mag_s7[i] <= mag_s6[i];
				nm_s8[i] <= sh_c[i][29:0];
				nm_s9[i] <= nm_s8[i];
				nsq_s9[i] <= 60'(nm_s8[i]) * 60'(nm_s8[i]);
				nm_s10[i] <= nm_s9[i];
			end
			if (rd > DOT_LIM)
				d_s3 <= 35'(DOT_LIM);
			else if (rd < -DOT_LIM)
				d_s3 <= 35'(-DOT_LIM);
			else
				d_s3 <= 35'(rd);
			m_s6 <= m_c;
			mr2_s6 <= 62'(mr_c) * 62'(mr_c);
			sgn_s6 <= sgn_s5;
			deg_s7 <= (m_s6 == '0) ||
				((m_s6[33:31] == 3'd0) && (r2_c < 64'(mr2_s6)));
			msb_s7 <= msb_c;
			sgn_s7 <= sgn_s6;
			deg_s8 <= deg_s7;
			sgn_s8 <= sgn_s7;
			deg_s9 <= deg_s8;
			sgn_s9 <= sgn_s8;
			r2n_s10 <= 62'(nsq_s9[0]) + 62'(nsq_s9[1]) + 62'(nsq_s9[2]);
			deg_s10 <= deg_s9;
			sgn_s10 <= sgn_s9;
		end
	end

	// Square root, restoring, two radicand bits per step.
	logic [33:0] srem_s [SQ_ST];
	logic [30:0] sroot_s [SQ_ST];
	logic [61:0] srad_s [SQ_ST];
	logic [29:0] snm_s [SQ_ST][3];
	logic [2:0]  ssgn_s [SQ_ST];
	logic        sdeg_s [SQ_ST];
	logic [33:0] srem_n [SQ_ST];
	logic [30:0] sroot_n [SQ_ST];
	logic [61:0] srad_n [SQ_ST];

	always_comb begin
		logic [33:0] rem, remt, trial;
		logic [30:0] root;
		logic [61:0] rad;
		for (int g = 0; g < SQ_ST; g++) begin
			if (g == 0) begin
				rem = '0;
				root = '0;
				rad = r2n_s10;
			end else begin
				rem = srem_s[g-1];
				root = sroot_s[g-1];
				rad = srad_s[g-1];
			end
			for (int l = 0; l < BITS_PER_STAGE; l++) begin
				if (g * BITS_PER_STAGE + l < SQ_ITERS) begin
					remt = {rem[31:0], rad[61:60]};
					trial = {1'b0, root, 2'b01};
					if (remt >= trial) begin
						rem = remt - trial;
						root = {root[29:0], 1'b1};
					end else begin
						rem = remt;
						root = {root[29:0], 1'b0};
					end
					rad = {rad[59:0], 2'b00};
				end
			end
			srem_n[g] = rem;
			sroot_n[g] = root;
			srad_n[g] = rad;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < SQ_ST; g++) begin
				srem_s[g] <= srem_n[g];
				sroot_s[g] <= sroot_n[g];
				srad_s[g] <= srad_n[g];
				if (g == 0) begin
					snm_s[g] <= nm_s10;
					ssgn_s[g] <= sgn_s10;
					sdeg_s[g] <= deg_s10;
				end else begin
					snm_s[g] <= snm_s[g-1];
					ssgn_s[g] <= ssgn_s[g-1];
					sdeg_s[g] <= sdeg_s[g-1];
				end
			end
		end
	end

	// Rounded divide (nm * 2^30 + n/2) / n, one quotient bit per step, three lanes.
	logic [31:0] dr_s [DV_ST][3];
	logic [30:0] dq_s [DV_ST][3];
	logic [30:0] db_s [DV_ST][3];
	logic [30:0] dn_s [DV_ST];
	logic [2:0]  dsgn_s [DV_ST];
	logic        ddeg_s [DV_ST];
	logic [31:0] dr_n [DV_ST][3];
	logic [30:0] dq_n [DV_ST][3];
	logic [30:0] db_n [DV_ST][3];

	always_comb begin
		logic [31:0] r, rt;
		logic [30:0] q, bits, n;
		for (int g = 0; g < DV_ST; g++) begin
			for (int i = 0; i < 3; i++) begin
				if (g == 0) begin
					n = sroot_s[SQ_ST-1];
					r = {3'b000, snm_s[SQ_ST-1][i][29:1]};
					bits = {snm_s[SQ_ST-1][i][0], n[30:1]};
					q = '0;
				end else begin
					n = dn_s[g-1];
					r = dr_s[g-1][i];
					bits = db_s[g-1][i];
					q = dq_s[g-1][i];
				end
				for (int l = 0; l < BITS_PER_STAGE; l++) begin
					if (g * BITS_PER_STAGE + l < DV_ITERS) begin
						rt = {r[30:0], bits[30]};
						if (rt >= {1'b0, n}) begin
							r = rt - {1'b0, n};
							q = {q[29:0], 1'b1};
						end else begin
							r = rt;
							q = {q[29:0], 1'b0};
						end
						bits = {bits[29:0], 1'b0};
					end
				end
				dr_n[g][i] = r;
				dq_n[g][i] = q;
				db_n[g][i] = bits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < DV_ST; g++) begin
				dr_s[g] <= dr_n[g];
				dq_s[g] <= dq_n[g];
				db_s[g] <= db_n[g];
				if (g == 0) begin
					dn_s[g] <= sroot_s[SQ_ST-1];
					dsgn_s[g] <= ssgn_s[SQ_ST-1];
					ddeg_s[g] <= sdeg_s[SQ_ST-1];
				end else begin
					dn_s[g] <= dn_s[g-1];
					dsgn_s[g] <= dsgn_s[g-1];
					ddeg_s[g] <= ddeg_s[g-1];
				end
			end
			for (int i = 0; i < 3; i++)
				u_s27[i] <= dsgn_s[DV_ST-1][i] ? -32'(dq_s[DV_ST-1][i])
					: 32'(dq_s[DV_ST-1][i]);
			sgn_s27 <= dsgn_s[DV_ST-1];
			deg_s27 <= ddeg_s[DV_ST-1];
		end
	end

	assign u.deg = deg_s27;
	assign u.u[0] = u_s27[0];
	assign u.u[1] = u_s27[1];
	assign u.u[2] = u_s27[2] | {31'd0, sgn_s27[2] & 1'b0};

endmodule

### rtl/axis_rotation_matrix_between_points_core.sv
// Top level: rotation matrix about a fixed axis carrying an origin point onto a destination.
//
// Each request carries an origin and a destination point (Q16.16). Both are moved by the
// configured center, projected onto the plane normal to the configured axis (Q2.30) and
// normalized; their dot and axis-weighted cross products give cos and sin of the turn, and
// the block returns the nine Rodrigues matrix entries in Q2.30, row-major. If either
// projection is zero or shorter than min_radius, the result is diag(axis) with degenerate
// set. The datapath is a 34-stage pipeline (33 compute stages plus the output register):
// a new request is taken every cycle while in_stall is low. That depth is set mostly by
// the square root and the three rounded dividers of each point, which resolve four bits
// per stage. in_stall rises only when a result waits in the output register and the last
// compute stage is full as well. Write the configuration registers only with no request
// in flight; there is no clearing pass after reset.
module axis_rotation_matrix_between_points_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dest_x,
	input  logic signed [COORD_WIDTH-1:0] dest_y,
	input  logic signed [COORD_WIDTH-1:0] dest_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            m00,
	output logic signed [31:0]            m01,
	output logic signed [31:0]            m02,
	output logic signed [31:0]            m10,
	output logic signed [31:0]            m11,
	output logic signed [31:0]            m12,
	output logic signed [31:0]            m20,
	output logic signed [31:0]            m21,
	output logic signed [31:0]            m22,
	output logic                          degenerate,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	import arpt_pkg::*;

	localparam int TOT = LANE_LAT + COMB_LAT;

	// Configuration registers.
	logic signed [31:0] center_q [3];
	logic signed [31:0] axis_q [3];
	logic [30:0]        minr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= ONE_Q30;
			minr_q <= 31'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTER_X:   center_q[0] <= cfg_data;
				REG_CENTER_Y:   center_q[1] <= cfg_data;
				REG_CENTER_Z:   center_q[2] <= cfg_data;
				REG_AXIS_X:     axis_q[0] <= cfg_data;
				REG_AXIS_Y:     axis_q[1] <= cfg_data;
				REG_AXIS_Z:     axis_q[2] <= cfg_data;
				REG_MIN_RADIUS: minr_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Clamp the axis to [-1, 1]; it is also what the degenerate result shows.
	logic signed [31:0] ksat [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (axis_q[i] > ONE_Q30)
				ksat[i] = ONE_Q30;
			else if (axis_q[i] < -ONE_Q30)
				ksat[i] = -ONE_Q30;
			else
				ksat[i] = axis_q[i];
		end
	end

	// Axis outer products k_i*k_j, refreshed every cycle; the user must keep config quiet
	// while requests fly, as the block does not enforce it. Order: 00, 11, 22, 01, 02, 12.
	logic signed [63:0] kkp_q [6];
	logic signed [31:0] kk_q [6];
	always_ff @(posedge clk) begin
		kkp_q[0] <= ksat[0] * ksat[0];
		kkp_q[1] <= ksat[1] * ksat[1];
		kkp_q[2] <= ksat[2] * ksat[2];
		kkp_q[3] <= ksat[0] * ksat[1];
		kkp_q[4] <= ksat[0] * ksat[2];
		kkp_q[5] <= ksat[1] * ksat[2];
		for (int j = 0; j < 6; j++)
			kk_q[j] <= 32'(rnd30(66'(kkp_q[j])));
	end

	// Pipeline flow: advance while the output register can take the last stage or that stage is empty.
	logic             out_valid_q;
	logic [TOT-1:0]   vld_q;
	logic             out_ready, en, accept;

	assign out_ready = !out_valid_q || !out_stall;
	assign en        = out_ready || !vld_q[TOT-1];
	assign in_stall  = !en;
	assign accept    = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TOT-2:0], accept};
	end

	// One projection lane per point.
	logic signed [COORD_WIDTH-1:0] po [3], pd [3];
	unit_t ua, ub;

	assign po[0] = origin_x;
	assign po[1] = origin_y;
	assign po[2] = origin_z;
	assign pd[0] = dest_x;
	assign pd[1] = dest_y;
	assign pd[2] = dest_z;

	arpt_ortho #(.COORD_WIDTH(COORD_WIDTH)) u_lane_a (
		.clk(clk), .en(en), .p(po), .center(center_q), .k(ksat),
		.min_radius(minr_q), .u(ua)
	);

	arpt_ortho #(.COORD_WIDTH(COORD_WIDTH)) u_lane_b (
		.clk(clk), .en(en), .p(pd), .center(center_q), .k(ksat),
		.min_radius(minr_q), .u(ub)
	);

	logic signed [31:0] a [3], b [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(ua.u[i]);
			b[i] = $signed(ub.u[i]);
		end
	end

	// Combine stages: dot and cross, c and w, k.w, s, k*s and t*kk, matrix.
	logic signed [63:0] pd_s28 [3];
	logic signed [63:0] px_s28 [6];
	logic               deg_s28, deg_s29, deg_s30, deg_s31, deg_s32, deg_s33;
	logic signed [31:0] c_s29, c_s30, c_s31, c_s32;
	logic signed [33:0] w_s29 [3];
	logic signed [65:0] kw_s30 [3];
	logic signed [32:0] t_s30, t_s31;
	logic signed [31:0] s_s31;
	logic signed [63:0] ks_s32 [3];
	logic signed [64:0] tkp_s32 [6];
	logic signed [31:0] m_s33 [9];

	logic signed [65:0] dsum, kwsum;
	logic signed [33:0] tk [6];
	logic signed [33:0] ksr [3];
	logic signed [65:0] mraw [9];
	logic signed [31:0] mdeg [9];

	always_comb begin
		dsum = 66'(pd_s28[0]) + 66'(pd_s28[1]) + 66'(pd_s28[2]);
		kwsum = kw_s30[0] + kw_s30[1] + kw_s30[2];
		for (int j = 0; j < 6; j++)
			tk[j] = 34'(rnd30(66'(tkp_s32[j])));
		for (int i = 0; i < 3; i++)
			ksr[i] = 34'(rnd30(66'(ks_s32[i])));
		mraw[0] = 66'(tk[0]) + 66'(c_s32);
		mraw[1] = 66'(tk[3]) - 66'(ksr[2]);
		mraw[2] = 66'(tk[4]) + 66'(ksr[1]);
		mraw[3] = 66'(tk[3]) + 66'(ksr[2]);
		mraw[4] = 66'(tk[1]) + 66'(c_s32);
		mraw[5] = 66'(tk[5]) - 66'(ksr[0]);
		mraw[6] = 66'(tk[4]) - 66'(ksr[1]);
		mraw[7] = 66'(tk[5]) + 66'(ksr[0]);
		mraw[8] = 66'(tk[2]) + 66'(c_s32);
		// Degenerate: diag(axis), zeros elsewhere.
		for (int e = 0; e < 9; e++)
			mdeg[e] = '0;
		mdeg[0] = ksat[0];
		mdeg[4] = ksat[1];
		mdeg[8] = ksat[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				pd_s28[i] <= a[i] * b[i];
			px_s28[0] <= a[1] * b[2];
			px_s28[1] <= a[2] * b[1];
			px_s28[2] <= a[2] * b[0];
			px_s28[3] <= a[0] * b[2];
			px_s28[4] <= a[0] * b[1];
			px_s28[5] <= a[1] * b[0];
			deg_s28 <= ua.deg || ub.deg;

			c_s29 <= sat30(rnd30(dsum));
			w_s29[0] <= 34'(rnd30(66'(px_s28[0]) - 66'(px_s28[1])));
			w_s29[1] <= 34'(rnd30(66'(px_s28[2]) - 66'(px_s28[3])));
			w_s29[2] <= 34'(rnd30(66'(px_s28[4]) - 66'(px_s28[5])));
			deg_s29 <= deg_s28;

			for (int i = 0; i < 3; i++)
				kw_s30[i] <= ksat[i] * w_s29[i];
			t_s30 <= 33'(ONE_Q30) - 33'(c_s29);
			c_s30 <= c_s29;
			deg_s30 <= deg_s29;

			s_s31 <= sat30(rnd30(kwsum));
			t_s31 <= t_s30;
			c_s31 <= c_s30;
			deg_s31 <= deg_s30;

			for (int i = 0; i < 3; i++)
				ks_s32[i] <= ksat[i] * s_s31;
			for (int j = 0; j < 6; j++)
				tkp_s32[j] <= t_s31 * kk_q[j];
			c_s32 <= c_s31;
			deg_s32 <= deg_s31;

			for (int e = 0; e < 9; e++)
				m_s33[e] <= deg_s32 ? mdeg[e] : sat30(mraw[e]);
			deg_s33 <= deg_s32;
		end
	end

	// Output register: take the last stage whenever the consumer side is free.
	logic signed [31:0] mo_q [9];
	logic               deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_ready)
			out_valid_q <= vld_q[TOT-1];
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			mo_q <= m_s33;
			deg_q <= deg_s33;
		end
	end

	assign out_valid  = out_valid_q;
	assign m00        = mo_q[0];
	assign m01        = mo_q[1];
	assign m02        = mo_q[2];
	assign m10        = mo_q[3];
	assign m11        = mo_q[4];
	assign m12        = mo_q[5];
	assign m20        = mo_q[6];
	assign m21        = mo_q[7];
	assign m22        = mo_q[8];
	assign degenerate = deg_q;

endmodule

### rtl/arpt_checker.sv
// Port-level checks for the axis rotation block, bound to its top level.
module arpt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] m00,
	input logic signed [31:0] m01,
	input logic signed [31:0] m02,
	input logic signed [31:0] m10,
	input logic signed [31:0] m11,
	input logic signed [31:0] m12,
	input logic signed [31:0] m20,
	input logic signed [31:0] m21,
	input logic signed [31:0] m22,
	input logic               degenerate
);
	import arpt_pkg::*;

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m11) &&
			$stable(m22) && $stable(degenerate))
		else $error("stalled result changed");

	// An empty output register never stalls requests.
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("request stalled with empty output");

	// Degenerate results carry only the diagonal.
	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> m01 == 0 && m02 == 0 && m10 == 0 &&
			m12 == 0 && m20 == 0 && m21 == 0)
		else $error("degenerate result has off-diagonal entries");

	// Diagonal entries stay within [-1, 1].
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m00 <= ONE_Q30 && m00 >= -ONE_Q30 && m11 <= ONE_Q30 &&
			m11 >= -ONE_Q30 && m22 <= ONE_Q30 && m22 >= -ONE_Q30)
		else $error("matrix entry out of range");

endmodule

bind axis_rotation_matrix_between_points_core arpt_checker u_arpt_checker (.*);

### verif/arpt_matrix_check.sv
// Channel monitor that predicts the rotation matrix of each request and compares results.
`timescale 1ns / 1ps

module arpt_matrix_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dest_x,
	input  logic signed [31:0] dest_y,
	input  logic signed [31:0] dest_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] m00,
	input  logic signed [31:0] m01,
	input  logic signed [31:0] m02,
	input  logic signed [31:0] m10,
	input  logic signed [31:0] m11,
	input  logic signed [31:0] m12,
	input  logic signed [31:0] m20,
	input  logic signed [31:0] m21,
	input  logic signed [31:0] m22,
	input  logic               degenerate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	import arpt_pkg::*;

	typedef struct {
		logic [31:0] m [9];
		logic        deg;
	} matrix_t;

	localparam longint Q30 = 64'sd1073741824;

	longint          center_r [3];
	longint          axis_r [3];
	longint unsigned min_r;
	matrix_t         matrix_q [$];

	function automatic longint rnd_sh(input longint x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(input longint x, input longint lim);
		return x > lim ? lim : (x < -lim ? -lim : x);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Unit vector of the point's projection onto the plane normal to k; 0 when too short.
	function automatic bit unit_proj(input longint p [3], input longint k [3],
	                                 output longint u [3]);
		longint          v [3], o [3], acc, d;
		longint unsigned mag [3], mx, r2, n, q;
		int              rs, ls;
		acc = 0;
		mx = 0;
		rs = 0;
		ls = 0;
		for (int i = 0; i < 3; i++) begin
			v[i] = p[i] - center_r[i];
			acc += (k[i] * v[i]) >>> 2;
		end
		d = clip(rnd_sh(acc, 28), (64'sd1 <<< 33) - 1);
		for (int i = 0; i < 3; i++) begin
			o[i] = v[i] - rnd_sh(d * k[i], 30);
			mag[i] = o[i] < 0 ? -o[i] : o[i];
			if (mag[i] > mx)
				mx = mag[i];
		end
		if (mx == 0)
			return 0;
		if (mx < (64'd1 << 31)) begin
			r2 = 0;
			for (int i = 0; i < 3; i++)
				r2 += mag[i] * mag[i];
			if (r2 < min_r * min_r)
				return 0;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			rs++;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			ls++;
		end
		r2 = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = rs != 0 ? (mag[i] >> rs) : (mag[i] << ls);
			r2 += mag[i] * mag[i];
		end
		n = int_sqrt(r2);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 30) + (n >> 1)) / n;
			u[i] = o[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic matrix_t rodrigues_matrix(input longint po [3], input longint pd [3]);
		matrix_t r;
		longint  k [3], a [3], b [3], w [3], mm [9], tk [3][3], ks [3], c, s, t;
		bit      ok_a, ok_b;
		for (int i = 0; i < 3; i++)
			k[i] = clip(axis_r[i], Q30);
		ok_a = unit_proj(po, k, a);
		ok_b = ok_a ? unit_proj(pd, k, b) : 0;
		if (!ok_b) begin
			for (int i = 0; i < 9; i++)
				r.m[i] = '0;
			r.m[0] = k[0][31:0];
			r.m[4] = k[1][31:0];
			r.m[8] = k[2][31:0];
			r.deg = 1'b1;
			return r;
		end
		c = clip(rnd_sh(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30), Q30);
		w[0] = rnd_sh(a[1] * b[2] - a[2] * b[1], 30);
		w[1] = rnd_sh(a[2] * b[0] - a[0] * b[2], 30);
		w[2] = rnd_sh(a[0] * b[1] - a[1] * b[0], 30);
		s = clip(rnd_sh(k[0] * w[0] + k[1] * w[1] + k[2] * w[2], 30), Q30);
		t = Q30 - c;
		for (int i = 0; i < 3; i++) begin
			ks[i] = rnd_sh(k[i] * s, 30);
			for (int j = 0; j < 3; j++)
				tk[i][j] = rnd_sh(t * rnd_sh(k[i] * k[j], 30), 30);
		end
		mm[0] = tk[0][0] + c;     mm[1] = tk[0][1] - ks[2]; mm[2] = tk[0][2] + ks[1];
		mm[3] = tk[0][1] + ks[2]; mm[4] = tk[1][1] + c;     mm[5] = tk[1][2] - ks[0];
		mm[6] = tk[0][2] - ks[1]; mm[7] = tk[1][2] + ks[0]; mm[8] = tk[2][2] + c;
		for (int i = 0; i < 9; i++)
			r.m[i] = clip(mm[i], Q30);
		r.deg = 1'b0;
		return r;
	endfunction

	assign pending = matrix_q.size();

	always @(posedge clk or negedge arst_n) begin
		longint  po [3], pd [3];
		matrix_t want, got;
		string   fname [10];
		int      nerr;
		fname = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22",
		          "degenerate"};
		nerr = 0;
		if (!arst_n) begin
			center_r = '{0, 0, 0};
			axis_r = '{0, 0, Q30};
			min_r = 1;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CENTER_X: center_r[0] = longint'(signed'(cfg_data));
					REG_CENTER_Y: center_r[1] = longint'(signed'(cfg_data));
					REG_CENTER_Z: center_r[2] = longint'(signed'(cfg_data));
					REG_AXIS_X: axis_r[0] = longint'(signed'(cfg_data));
					REG_AXIS_Y: axis_r[1] = longint'(signed'(cfg_data));
					REG_AXIS_Z: axis_r[2] = longint'(signed'(cfg_data));
					REG_MIN_RADIUS: min_r = cfg_data[30:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				po = '{origin_x, origin_y, origin_z};
				pd = '{dest_x, dest_y, dest_z};
				matrix_q.push_back(rodrigues_matrix(po, pd));
			end
			if (out_valid && !out_stall) begin
				if (matrix_q.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					nerr++;
				end else begin
					want = matrix_q.pop_front();
					got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
					got.deg = degenerate;
					for (int i = 0; i < 9; i++)
						if (got.m[i] !== want.m[i]) begin
							$display("%0t: %s expected %0d actual %0d", $time, fname[i],
							         signed'(want.m[i]), signed'(got.m[i]));
							nerr++;
						end
					if (got.deg !== want.deg) begin
						$display("%0t: %s expected %0b actual %0b", $time, fname[9],
						         want.deg, got.deg);
						nerr++;
					end
				end
				errors <= errors + nerr;
			end
		end
	end

endmodule

### verif/tb.sv
// Testbench top: drives requests and configuration, stalls results, gives the verdict.
`timescale 1ns / 1ps

module tb;
	import arpt_pkg::*;

	localparam int     WATCHDOG = 20000;
	localparam int     DRAIN = 40;
	localparam longint Q30 = 64'sd1073741824;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] dest_x = '0, dest_y = '0, dest_z = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic              degenerate;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [31:0]       cfg_data = '0;
	int                errors, pending;

	// Mirror of the register file, used to aim points at the axis.
	longint            reg_val [7];
	int                burst_left = 0;
	int                stall_mode = 0, stall_left = 0;
	int                idle_cycles = 0;

	always #4 clk = ~clk;

	axis_rotation_matrix_between_points_core dut (.*);
	arpt_matrix_check chk (.*);

	// Receiver: switch among stall patterns, including stretches with no stall at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(50, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= $urandom_range(0, 1);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Watchdog: end the run if no request or result moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Drop valid, then let the pipeline drain before touching the registers.
	task automatic settle();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[31:0];
		if (idx <= REG_MIN_RADIUS)
			reg_val[idx] = idx == REG_MIN_RADIUS ? longint'(val[30:0])
			                                     : longint'(signed'(val[31:0]));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input longint cx, cy, cz, ax, ay, az, mr);
		settle();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_AXIS_X, ax);
		write_reg(REG_AXIS_Y, ay);
		write_reg(REG_AXIS_Z, az);
		write_reg(REG_MIN_RADIUS, mr);
	endtask

	// Hold the request until it is taken; bursts of back-to-back requests, random gaps.
	task automatic send(input longint ox, oy, oz, dx, dy, dz);
		if (burst_left == 0) begin
			if (in_valid) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		origin_x <= ox[31:0];
		origin_y <= oy[31:0];
		origin_z <= oz[31:0];
		dest_x <= dx[31:0];
		dest_y <= dy[31:0];
		dest_z <= dz[31:0];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic longint rand_full();
		return longint'(signed'(32'($urandom())));
	endfunction

	function automatic longint rand_axis_comp();
		return longint'($urandom_range(0, 32'h8000_0000)) - Q30;
	endfunction

	// Random point: full range, moderate, on the axis, or near the min radius.
	function automatic longint pick_point(input int i, input int kind, input longint t);
		longint base;
		base = reg_val[i] + ((t * reg_val[3 + i]) >>> 30);
		case (kind)
			0: return rand_full();
			1: return base;
			2: return base + $urandom_range(0, 2 * (reg_val[6] & 32'hffff) + 4)
			            - (reg_val[6] & 32'hffff) - 2;
			default: return reg_val[i] + $signed($urandom_range(0, 32'h01ff_ffff))
			                - 64'sd16777216;
		endcase
	endfunction

	task automatic random_items(input int count);
		longint p [6], t;
		int     kind;
		for (int n = 0; n < count; n++) begin
			for (int e = 0; e < 2; e++) begin
				kind = $urandom_range(0, 9);
				kind = kind < 2 ? 0 : (kind < 3 ? 1 : (kind < 4 ? 2 : 3));
				t = $signed($urandom_range(0, 32'h00ff_ffff)) - 64'sd8388608;
				for (int i = 0; i < 3; i++)
					p[3 * e + i] = pick_point(i, kind, t);
			end
			send(p[0], p[1], p[2], p[3], p[4], p[5]);
		end
	endtask

	initial begin
		longint mx, mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		reg_val = '{0, 0, 0, 0, 0, Q30, 1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: axis along z, center at the origin.
		send(0, 0, 0, 0, 0, 0);
		send(1, 0, 0, 0, 1, 0);
		send(65536, 0, 7, -65536, 0, 9);
		send(65536, 0, 0, 65536, 0, 0);
		send(mx, mx, mx, mn, mn, mn);
		send(mn, mx, 0, mx, mn, 0);
		send(0, 0, 123456, 65536, 65536, 0);
		send(65536, 65536, 0, 0, 0, mx);
		send(mx, 0, 0, 0, mx, 0);
		send(0, mn, 0, mx, 0, 0);

		// Oblique unit axis, offset center, large min radius.
		set_all(65536, -131072, 3 <<< 16, 619925131, 619925131, 619925131, 1 <<< 20);
		send(65536, -131072, 3 <<< 16, 1 <<< 22, 0, 0);
		send(1 <<< 22, 0, 0, 0, 1 <<< 22, 0);
		send(0, 1 <<< 22, 0, 1 <<< 22, 0, 0);
		send(65536 + 100, -131072, 3 <<< 16, 1 <<< 22, 0, 0);
		send(mx, mn, mx, mn, mx, mn);
		random_items(170);

		// Out-of-range axis components and extreme center, zero min radius.
		set_all(mx, mn, mx, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
		send(mx, mn, 0, mx, mn, 1);
		send(0, 0, 0, mx, mx, mx);
		send(mx, mn, mx, mn, mx, mn);
		random_items(170);

		// Largest min radius: almost everything degenerates.
		set_all(mn, mx, mn, 0, Q30, 0, 32'h7fff_ffff);
		send(0, 0, 0, 0, 0, 0);
		send(mx, mx, mx, mn, mn, mn);
		random_items(100);

		// Axis along -x, min radius zero.
		set_all(0, 0, 0, -Q30, 0, 0, 0);
		send(5, 0, 0, 0, 1, 0);
		send(0, 1, 0, 0, -1, 0);
		random_items(170);

		// Random axes and centers, mostly unit axes in the xy plane or random non-unit.
		for (int ph = 0; ph < 5; ph++) begin
			if (ph % 2 == 0)
				set_all(rand_full(), rand_full(), rand_full(), 644245094, 858993459, 0,
				        $urandom_range(0, 32'h0001_0000));
			else
				set_all($signed($urandom_range(0, 32'h00ff_ffff)) - 64'sd8388608,
				        rand_full() >>> 8, rand_full() >>> 8, rand_axis_comp(),
				        rand_axis_comp(), rand_axis_comp(), $urandom_range(0, 32'h0010_0000));
			random_items(180);
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending != 0)
			$display("%0t: %0d results never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/arpt_pkg.sv
rtl/arpt_ortho.sv
rtl/axis_rotation_matrix_between_points_core.sv
rtl/arpt_checker.sv
verif/arpt_matrix_check.sv
verif/tb.sv
